### rtl/rlss_pkg.sv
// shared types and constants for the rgb led strip serializer
package rlss_pkg;

   // default number of leds the pixel memory holds
   localparam int MAX_LEDS_DEF = 16;

   // field widths
   localparam int OP_W        = 2;
   localparam int LED_IDX_W   = 4;
   localparam int COLOR_W     = 8;
   localparam int PCT_W       = 8;
   localparam int BIT_TICK_W  = 8;
   localparam int TICK_W      = 10;
   localparam int COUNT_W     = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int ROW_W       = 3 * COLOR_W;

   // brightness scaling: floor(c * pct / 100) as (c * pct * RECIP) >> RECIP_SHIFT
   localparam int SCALE_PCT_W = 7;
   localparam int PROD_W      = COLOR_W + SCALE_PCT_W;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP    = 13'd5243;
   localparam logic [PCT_W-1:0]   PCT_FULL = 8'd100;

   // register reset values
   localparam logic [BIT_TICK_W-1:0] ZERO_HIGH_RST = 8'd3;
   localparam logic [BIT_TICK_W-1:0] ZERO_LOW_RST  = 8'd9;
   localparam logic [BIT_TICK_W-1:0] ONE_HIGH_RST  = 8'd9;
   localparam logic [BIT_TICK_W-1:0] ONE_LOW_RST   = 8'd3;
   localparam logic [TICK_W-1:0]     LATCH_RST     = 10'd500;
   localparam logic [COUNT_W-1:0]    LED_COUNT_RST = 5'd12;

   // item opcodes
   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_HIGH = 3'd0,
      CSR_ZERO_LOW  = 3'd1,
      CSR_ONE_HIGH  = 3'd2,
      CSR_ONE_LOW   = 3'd3,
      CSR_LATCH     = 3'd4,
      CSR_LED_COUNT = 3'd5
   } csr_index_type;

   // command from the frame sequencer to the pixel store
   typedef struct packed {
      logic                 set_en;
      logic                 clear_en;
      logic [LED_IDX_W-1:0] led_index;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic [PCT_W-1:0]     pct;
   } pix_cmd_type;

endpackage

### rtl/rgb_led_strip_serializer.sv
// rgb led strip serializer: one-wire frame sequencer, registers and response queue
// response: a result is registered in the head register, or in the skid entry while the head is held
// throughput: one beat per cycle while the skid entry is empty; after a set beat the input stalls while
//   its scaled row goes through the single write port of the pixel memory
// reset: synchronous, loads control and registers with reset values and clears row valid bits; no memory sweep
module rgb_led_strip_serializer
   import rlss_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [LED_IDX_W-1:0]  req_led_index,
   input  logic [COLOR_W-1:0]    req_red_in,
   input  logic [COLOR_W-1:0]    req_green_in,
   input  logic [COLOR_W-1:0]    req_blue_in,
   input  logic [PCT_W-1:0]      req_brightness_pct,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_line_level,
   output logic                  rsp_busy_res,
   output logic                  rsp_accepted,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int LED_W = $clog2(MAX_LEDS + 1);
   localparam int CNT_W = (LED_W > COUNT_W) ? LED_W : COUNT_W;

   localparam logic [1:0] SLOT_GREEN = 2'd0;
   localparam logic [1:0] SLOT_BLUE  = 2'd1;
   localparam logic [1:0] SLOT_RED   = 2'd2;
   localparam logic [2:0] BIT_LAST   = 3'd7;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_LATCH
   } phase_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

   // configuration registers
   logic [BIT_TICK_W-1:0] zero_high_ff;
   logic [BIT_TICK_W-1:0] zero_low_ff;
   logic [BIT_TICK_W-1:0] one_high_ff;
   logic [BIT_TICK_W-1:0] one_low_ff;
   logic [TICK_W-1:0]     latch_ff;
   logic [COUNT_W-1:0]    led_count_ff;

   // frame state
   phase_type             phase_ff, phase_in;
   logic [LED_W-1:0]      led_ff, led_in;
   logic [1:0]            slot_ff, slot_in;
   logic [2:0]            bit_ff, bit_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;
   logic                  line_ff, line_in;

   // response queue: head register and skid entry
   rsp_type               head_ff, head_in;
   logic                  head_valid_ff, head_valid_in;
   rsp_type               skid_ff, skid_in;
   logic                  skid_valid_ff, skid_valid_in;

   logic                  req_take;
   logic                  rsp_take;
   logic                  acc;
   rsp_type               rsp_new;
   pix_cmd_type           cmd;
   logic                  wr_busy;
   logic [ROW_W-1:0]      cur_row;
   logic [COLOR_W-1:0]    cur_byte;
   logic                  cur_bit;
   logic [BIT_TICK_W-1:0] bit_high;
   logic [BIT_TICK_W-1:0] bit_low;
   logic [BIT_TICK_W:0]   bit_len;
   logic [TICK_W:0]       tick_next;
   logic [TICK_W:0]       latch_cnt;
   logic                  latch_end;
   logic [CNT_W-1:0]      active;
   logic [LED_W-1:0]      led_inc;
   logic                  frame_done;
   logic                  idx_ok;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = head_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff || wr_busy;
   assign csr_ready = 1'b1;

   // pixel memory
   rlss_pixel_store #(
      .MAX_LEDS (MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_addr (led_in[IDX_W-1:0]),
      .rd_row  (cur_row),
      .wr_busy (wr_busy)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= ZERO_HIGH_RST;
         zero_low_ff  <= ZERO_LOW_RST;
         one_high_ff  <= ONE_HIGH_RST;
         one_low_ff   <= ONE_LOW_RST;
         latch_ff     <= LATCH_RST;
         led_count_ff <= LED_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_HIGH: zero_high_ff <= csr_data[BIT_TICK_W-1:0];
            CSR_ZERO_LOW:  zero_low_ff  <= csr_data[BIT_TICK_W-1:0];
            CSR_ONE_HIGH:  one_high_ff  <= csr_data[BIT_TICK_W-1:0];
            CSR_ONE_LOW:   one_low_ff   <= csr_data[BIT_TICK_W-1:0];
            CSR_LATCH:     latch_ff     <= csr_data[TICK_W-1:0];
            CSR_LED_COUNT: led_count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // leds in a frame, limited to the memory depth
   assign active = (CNT_W'(led_count_ff) > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                             : CNT_W'(led_count_ff);
   assign idx_ok     = CNT_W'(req_led_index) < active;
   assign frame_done = CNT_W'(led_ff) >= active;
   assign led_inc    = led_ff + LED_W'(1);

   // current bit on the line, msb first
   always_comb begin
      case (slot_ff)
         SLOT_GREEN: cur_byte = cur_row[3*COLOR_W-1:2*COLOR_W];
         SLOT_BLUE:  cur_byte = cur_row[2*COLOR_W-1:COLOR_W];
         default:    cur_byte = cur_row[COLOR_W-1:0];
      endcase
   end
   assign cur_bit   = cur_byte[BIT_LAST - bit_ff];
   assign bit_high  = cur_bit ? one_high_ff : zero_high_ff;
   assign bit_low   = cur_bit ? one_low_ff : zero_low_ff;
   assign bit_len   = {1'b0, bit_high} + {1'b0, bit_low};
   assign tick_next = {1'b0, ticks_ff} + (TICK_W+1)'(1);

   // reset code count: a data phase with nothing left starts it on this tick
   assign latch_cnt = (phase_ff == PH_DATA) ? (TICK_W+1)'(1) : tick_next;
   assign latch_end = latch_cnt >= {1'b0, latch_ff};

   // frame sequencer
   always_comb begin
      phase_in = phase_ff;
      led_in   = led_ff;
      slot_in  = slot_ff;
      bit_in   = bit_ff;
      ticks_in = ticks_ff;
      line_in  = line_ff;
      acc      = 1'b0;

      cmd.set_en    = 1'b0;
      cmd.clear_en  = 1'b0;
      cmd.led_index = req_led_index;
      cmd.red       = req_red_in;
      cmd.green     = req_green_in;
      cmd.blue      = req_blue_in;
      cmd.pct       = req_brightness_pct;

      if (req_take) begin
         case (req_opcode)
            OP_TICK: begin
               acc = 1'b1;
               if (phase_ff == PH_DATA && !frame_done) begin
                  // data bit: high then low
                  line_in = {2'b00, ticks_ff} < {3'b000, bit_high};
                  if (tick_next >= (TICK_W+1)'(bit_len)) begin
                     ticks_in = '0;
                     if (bit_ff == BIT_LAST) begin
                        bit_in = '0;
                        if (slot_ff == SLOT_RED) begin
                           slot_in = SLOT_GREEN;
                           led_in  = led_inc;
                           if (CNT_W'(led_inc) >= active) begin
                              phase_in = PH_LATCH;
                           end
                        end else begin
                           slot_in = slot_ff + 2'd1;
                        end
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end else begin
                     ticks_in = tick_next[TICK_W-1:0];
                  end
               end else if (phase_ff == PH_DATA || phase_ff == PH_LATCH) begin
                  // reset code: line low
                  line_in = 1'b0;
                  if (latch_end) begin
                     phase_in = PH_IDLE;
                     ticks_in = '0;
                     led_in   = '0;
                     slot_in  = SLOT_GREEN;
                     bit_in   = '0;
                  end else begin
                     phase_in = PH_LATCH;
                     ticks_in = latch_cnt[TICK_W-1:0];
                  end
               end else begin
                  line_in = 1'b0;
               end
            end
            OP_SET: begin
               if (phase_ff == PH_IDLE && idx_ok) begin
                  cmd.set_en = 1'b1;
                  acc        = 1'b1;
               end
            end
            OP_CLEAR: begin
               if (phase_ff == PH_IDLE) begin
                  cmd.clear_en = 1'b1;
                  acc          = 1'b1;
               end
            end
            default: ;
         endcase

         // start of frame
         if (cmd.set_en || cmd.clear_en) begin
            phase_in = PH_DATA;
            led_in   = '0;
            slot_in  = SLOT_GREEN;
            bit_in   = '0;
            ticks_in = '0;
            line_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         led_ff   <= '0;
         slot_ff  <= SLOT_GREEN;
         bit_ff   <= '0;
         ticks_ff <= '0;
         line_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         led_ff   <= led_in;
         slot_ff  <= slot_in;
         bit_ff   <= bit_in;
         ticks_ff <= ticks_in;
         line_ff  <= line_in;
      end
   end

   // response beat for the request taken this cycle
   assign rsp_new.line_level = line_in;
   assign rsp_new.busy_res   = phase_in != PH_IDLE;
   assign rsp_new.accepted   = acc;

   // response queue
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            head_in       = rsp_new;
            head_valid_in = req_take;
         end
      end else if (req_take) begin
         skid_in       = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = head_valid_ff;
   assign rsp_line_level = head_ff.line_level;
   assign rsp_busy_res   = head_ff.busy_res;
   assign rsp_accepted   = head_ff.accepted;

endmodule

### rtl/rlss_pixel_store.sv
// pixel memory with brightness scaling write pipeline and row valid bits
module rlss_pixel_store
   import rlss_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF,
   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  pix_cmd_type       cmd,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [ROW_W-1:0]  rd_row,
   output logic              wr_busy
);

   localparam int FULL_W = PROD_W + RECIP_W;

   // one row per led: green, blue, red from msb down
   logic [ROW_W-1:0]       pixel_mem [MAX_LEDS];
   logic [MAX_LEDS-1:0]    row_valid_ff;

   logic [SCALE_PCT_W-1:0] pct_clamped;
   logic                   wr_pend_ff;
   logic [IDX_W-1:0]       wr_addr_ff;
   logic [PROD_W-1:0]      prod_g_ff;
   logic [PROD_W-1:0]      prod_b_ff;
   logic [PROD_W-1:0]      prod_r_ff;
   logic [ROW_W-1:0]       wr_row;
   logic                   wr_hit;
   logic [ROW_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;

   // divide by 100 through a reciprocal multiply, exact for products below 25600
   function automatic logic [COLOR_W-1:0] pct_scale(input logic [PROD_W-1:0] prod);
      logic [FULL_W-1:0] full;
      full = FULL_W'(prod) * FULL_W'(RECIP);
      return full[RECIP_SHIFT +: COLOR_W];
   endfunction

   // brightness clamps at full
   assign pct_clamped = (cmd.pct > PCT_FULL) ? PCT_FULL[SCALE_PCT_W-1:0]
                                             : cmd.pct[SCALE_PCT_W-1:0];

   // first write stage: color times percent
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.set_en;
      end
      if (cmd.set_en) begin
         wr_addr_ff <= IDX_W'(cmd.led_index);
         prod_g_ff  <= PROD_W'(cmd.green) * PROD_W'(pct_clamped);
         prod_b_ff  <= PROD_W'(cmd.blue) * PROD_W'(pct_clamped);
         prod_r_ff  <= PROD_W'(cmd.red) * PROD_W'(pct_clamped);
      end
   end

   // second write stage: divide and store the row
   assign wr_row = {pct_scale(prod_g_ff), pct_scale(prod_b_ff), pct_scale(prod_r_ff)};
   assign wr_hit = wr_pend_ff && (wr_addr_ff == rd_addr);

   // memory port, write data forwarded to a read of the same row
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         pixel_mem[wr_addr_ff] <= wr_row;
      end
      rd_data_ff <= wr_hit ? wr_row : pixel_mem[rd_addr];
   end

   // row valid bits: cleared rows read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            row_valid_ff <= '0;
         end else if (wr_pend_ff) begin
            row_valid_ff[wr_addr_ff] <= 1'b1;
         end
         rd_valid_ff <= !cmd.clear_en && (wr_hit || row_valid_ff[rd_addr]);
      end
   end

   assign rd_row  = rd_valid_ff ? rd_data_ff : '0;
   assign wr_busy = wr_pend_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the rgb led strip serializer: tracks the strip state and checks every response beat
module tb_top;
   import rlss_pkg::*;

   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 5;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int MAX_REPORTS     = 10;
   localparam int MAX_WAIT        = 17;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int STORE_BYTES     = 3 * MAX_LEDS_DEF;

   typedef enum logic [1:0] {
      FRAME_IDLE,
      FRAME_DATA,
      FRAME_LATCH
   } frame_phase_type;

   typedef struct packed {
      logic line_level;
      logic busy;
      logic accepted;
   } line_result_type;

   // strip state tracker and the line levels it expects back, oldest first
   class strip_tracker;
      logic [COLOR_W-1:0]    pixels [STORE_BYTES];
      logic [5:0]            byte_pos;
      logic [2:0]            bit_pos;
      frame_phase_type       phase;
      logic [TICK_W-1:0]     phase_ticks;
      logic                  line_q;
      logic [BIT_TICK_W-1:0] zero_high;
      logic [BIT_TICK_W-1:0] zero_low;
      logic [BIT_TICK_W-1:0] one_high;
      logic [BIT_TICK_W-1:0] one_low;
      logic [TICK_W-1:0]     latch_len;
      logic [COUNT_W-1:0]    led_count;
      line_result_type       pending_levels [$];
      int                    mismatch_count;
      int                    beat_count;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         byte_pos       = '0;
         bit_pos        = '0;
         phase          = FRAME_IDLE;
         phase_ticks    = '0;
         line_q         = 1'b0;
         zero_high      = ZERO_HIGH_RST;
         zero_low       = ZERO_LOW_RST;
         one_high       = ONE_HIGH_RST;
         one_low        = ONE_LOW_RST;
         latch_len      = LATCH_RST;
         led_count      = LED_COUNT_RST;
         mismatch_count = 0;
         beat_count     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ZERO_HIGH: zero_high = value[BIT_TICK_W-1:0];
            CSR_ZERO_LOW:  zero_low  = value[BIT_TICK_W-1:0];
            CSR_ONE_HIGH:  one_high  = value[BIT_TICK_W-1:0];
            CSR_ONE_LOW:   one_low   = value[BIT_TICK_W-1:0];
            CSR_LATCH:     latch_len = value[TICK_W-1:0];
            CSR_LED_COUNT: led_count = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [COUNT_W-1:0] active_leds();
         return (led_count > MAX_LEDS_DEF) ? COUNT_W'(MAX_LEDS_DEF) : led_count;
      endfunction

      // floor(c * pct / 100), pct already clamped
      function logic [COLOR_W-1:0] scaled(logic [COLOR_W-1:0] c, logic [PCT_W-1:0] pct);
         logic [PROD_W-1:0] prod;
         prod = PROD_W'(c) * PROD_W'(pct);
         return COLOR_W'(prod / PROD_W'(100));
      endfunction

      function void start_frame();
         phase       = FRAME_DATA;
         byte_pos    = '0;
         bit_pos     = '0;
         phase_ticks = '0;
         line_q      = 1'b0;
      endfunction

      // one timing tick of the serial line
      function void advance_tick();
         logic [6:0]            nbytes;
         logic                  one_bit;
         logic [BIT_TICK_W-1:0] hi_len;
         logic [BIT_TICK_W-1:0] lo_len;
         nbytes = 7'(active_leds()) * 7'd3;
         if (phase == FRAME_DATA) begin
            if (7'(byte_pos) >= nbytes) begin
               // strip shrank under the frame: fall through to the reset code
               phase       = FRAME_LATCH;
               phase_ticks = '0;
            end else begin
               one_bit = pixels[byte_pos][3'd7 - bit_pos];
               hi_len  = one_bit ? one_high : zero_high;
               lo_len  = one_bit ? one_low : zero_low;
               line_q  = (phase_ticks < TICK_W'(hi_len));
               phase_ticks = phase_ticks + 1'b1;
               if (phase_ticks >= TICK_W'(hi_len) + TICK_W'(lo_len)) begin
                  phase_ticks = '0;
                  if (bit_pos == 3'd7) begin
                     bit_pos  = '0;
                     byte_pos = byte_pos + 1'b1;
                     if (7'(byte_pos) >= nbytes) phase = FRAME_LATCH;
                  end else begin
                     bit_pos = bit_pos + 1'b1;
                  end
               end
               return;
            end
         end
         if (phase == FRAME_LATCH) begin
            line_q      = 1'b0;
            phase_ticks = phase_ticks + 1'b1;
            if (phase_ticks >= latch_len) begin
               phase       = FRAME_IDLE;
               phase_ticks = '0;
               byte_pos    = '0;
               bit_pos     = '0;
            end
            return;
         end
         line_q = 1'b0;
      endfunction

      // accepted request beat: update the strip and queue the expected response
      function void note_command(opcode_type op, logic [LED_IDX_W-1:0] idx,
                                 logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                 logic [COLOR_W-1:0] blue, logic [PCT_W-1:0] pct);
         logic            took;
         logic [PCT_W-1:0] pct_eff;
         int              row;
         line_result_type want;
         took    = 1'b0;
         pct_eff = (pct > PCT_FULL) ? PCT_FULL : pct;
         row     = 3 * int'(idx);
         case (op)
            OP_TICK: begin
               advance_tick();
               took = 1'b1;
            end
            OP_SET: begin
               if (phase == FRAME_IDLE && COUNT_W'(idx) < active_leds()) begin
                  // stored order is green, blue, red
                  pixels[row]     = scaled(green, pct_eff);
                  pixels[row + 1] = scaled(blue, pct_eff);
                  pixels[row + 2] = scaled(red, pct_eff);
                  start_frame();
                  took = 1'b1;
               end
            end
            OP_CLEAR: begin
               if (phase == FRAME_IDLE) begin
                  foreach (pixels[i]) pixels[i] = '0;
                  start_frame();
                  took = 1'b1;
               end
            end
            default: ;
         endcase
         want.line_level = line_q;
         want.busy       = (phase != FRAME_IDLE);
         want.accepted   = took;
         pending_levels.push_back(want);
      endfunction

      function void compare_field(string name, logic want, logic got);
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: beat %0d %s mismatch: expected %0b, got %0b",
                        $time, beat_count, name, want, got);
         end
      endfunction

      // accepted response beat: compare with the oldest expectation
      function void check_level(logic line_level, logic busy, logic accepted);
         line_result_type want;
         beat_count++;
         if (pending_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response beat %0d with nothing expected (line %0b busy %0b acc %0b)",
                        $time, beat_count, line_level, busy, accepted);
            return;
         end
         want = pending_levels.pop_front();
         compare_field("line_level", want.line_level, line_level);
         compare_field("busy_res", want.busy, busy);
         compare_field("accepted", want.accepted, accepted);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_opcode;
   logic [LED_IDX_W-1:0]  req_led_index;
   logic [COLOR_W-1:0]    req_red_in;
   logic [COLOR_W-1:0]    req_green_in;
   logic [COLOR_W-1:0]    req_blue_in;
   logic [PCT_W-1:0]      req_brightness_pct;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_line_level;
   logic                  rsp_busy_res;
   logic                  rsp_accepted;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   strip_tracker tracker = new();
   bit           send_quiet;
   bit           recv_quiet;
   int           cycle_count = 0;

   rgb_led_strip_serializer uut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // idle cycles before a beat: none in quiet stretches, otherwise often some
   function automatic int draw_wait(bit quiet);
      if (quiet || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [COLOR_W-1:0] rand_color();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [PCT_W-1:0] rand_pct();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return PCT_FULL;
         2, 3:    return PCT_W'($urandom_range(101, 255));
         default: return PCT_W'($urandom_range(1, 99));
      endcase
   endfunction

   // one request beat, noted in the tracker at the edge it is taken
   task automatic send_item(opcode_type op, logic [LED_IDX_W-1:0] idx,
                            logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                            logic [COLOR_W-1:0] blue, logic [PCT_W-1:0] pct);
      int gap;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_led_index      <= idx;
      req_red_in         <= red;
      req_green_in       <= green;
      req_blue_in        <= blue;
      req_brightness_pct <= pct;
      do @(posedge clock); while (req_stall);
      tracker.note_command(op, idx, red, green, blue, pct);
   endtask

   // tick beat with junk in the unused fields
   task automatic send_tick();
      send_item(OP_TICK, LED_IDX_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                COLOR_W'($urandom), PCT_W'($urandom));
   endtask

   // tick until the frame and its reset code are done
   task automatic finish_frame();
      while (tracker.phase != FRAME_IDLE) send_tick();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, value);
   endtask

   // all six registers, written once the response side has drained
   task automatic apply_settings(logic [CSR_DATA_W-1:0] zh, logic [CSR_DATA_W-1:0] zl,
                                 logic [CSR_DATA_W-1:0] oh, logic [CSR_DATA_W-1:0] ol,
                                 logic [CSR_DATA_W-1:0] lt, logic [CSR_DATA_W-1:0] lc);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_ZERO_HIGH, zh);
      write_csr(CSR_ZERO_LOW, zl);
      write_csr(CSR_ONE_HIGH, oh);
      write_csr(CSR_ONE_LOW, ol);
      write_csr(CSR_LATCH, lt);
      write_csr(CSR_LED_COUNT, lc);
      csr_valid <= 1'b0;
   endtask

   // mostly ticks, some sets (usually in range), a few clears
   task automatic random_item();
      int                   pick;
      logic [LED_IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
         send_tick();
      end else if (pick < 96) begin
         if ($urandom_range(0, 3) != 0)
            idx = LED_IDX_W'($urandom_range(0, int'(tracker.active_leds()) - 1));
         else
            idx = LED_IDX_W'($urandom_range(0, 15));
         send_item(OP_SET, idx, rand_color(), rand_color(), rand_color(), rand_pct());
      end else begin
         send_item(OP_CLEAR, LED_IDX_W'($urandom), rand_color(), rand_color(), rand_color(),
                   rand_pct());
      end
   endtask

   // response side: random stalls, with quiet stretches
   initial begin
      int hold;
      int stretch_left;
      rsp_stall    <= 1'b0;
      recv_quiet   = 1'b0;
      stretch_left = 40;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stretch_left == 0) begin
            recv_quiet   = !recv_quiet;
            stretch_left = $urandom_range(20, 80);
         end
         stretch_left--;
         hold = draw_wait(recv_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_level(rsp_line_level, rsp_busy_res, rsp_accepted);
      end
   end

   // stimulus
   initial begin
      logic [CSR_DATA_W-1:0] lc;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_opcode         <= OP_TICK;
      req_led_index      <= '0;
      req_red_in         <= '0;
      req_green_in       <= '0;
      req_blue_in        <= '0;
      req_brightness_pct <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= CSR_ZERO_HIGH;
      csr_data           <= '0;
      send_quiet         = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset values: idle tick, out-of-range sets, clamped set, refusals while busy
      send_item(OP_TICK, 4'd0, 8'h00, 8'h00, 8'h00, 8'd0);
      send_item(OP_SET, 4'd12, 8'hff, 8'hff, 8'hff, 8'd100);
      send_item(OP_SET, 4'd15, 8'hff, 8'hff, 8'hff, 8'd100);
      send_item(OP_SET, 4'd11, 8'hff, 8'h00, 8'h80, 8'hff);
      send_item(OP_SET, 4'd0, 8'h12, 8'h34, 8'h56, 8'd50);
      send_item(OP_CLEAR, 4'd0, 8'h00, 8'h00, 8'h00, 8'd0);
      finish_frame();

      // fastest bits on the longest strip
      apply_settings(1, 1, 1, 1, 1, 16);
      send_item(OP_SET, 4'd15, 8'hff, 8'hff, 8'hff, 8'd100);
      finish_frame();
      send_item(OP_SET, 4'd0, 8'hff, 8'hff, 8'hff, 8'd0);
      finish_frame();
      send_item(OP_SET, 4'd7, 8'haa, 8'h55, 8'h01, 8'd101);
      finish_frame();

      // strip shrinks mid-frame: position already past the end goes to the reset code
      send_item(OP_SET, 4'd9, 8'h81, 8'h42, 8'h24, 8'd99);
      repeat (300) send_tick();
      apply_settings(1, 1, 1, 1, 1023, 2);
      repeat (100) send_tick();

      // reset code shortened under a count already past it
      apply_settings(2, 1, 1, 2, 10, 2);
      finish_frame();
      send_item(OP_CLEAR, 4'd3, 8'hff, 8'hff, 8'hff, 8'hff);
      finish_frame();

      // slowest bits and longest reset code on a single led
      apply_settings(255, 255, 255, 255, 1023, 1);
      send_item(OP_SET, 4'd1, 8'hff, 8'hff, 8'hff, 8'd100);
      send_item(OP_SET, 4'd0, rand_color(), rand_color(), rand_color(), 8'd100);
      finish_frame();

      // random phases with short timings, registers rewritten between them
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if ($urandom_range(0, 5) == 0) lc = CSR_DATA_W'($urandom_range(4, 16));
         else lc = CSR_DATA_W'($urandom_range(1, 3));
         apply_settings(CSR_DATA_W'($urandom_range(1, 3)), CSR_DATA_W'($urandom_range(1, 3)),
                        CSR_DATA_W'($urandom_range(1, 3)), CSR_DATA_W'($urandom_range(1, 3)),
                        CSR_DATA_W'($urandom_range(1, 16)), lc);
         send_quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 149) == 0) wait_drained();
            random_item();
         end
      end

      // drain and report
      wait_drained();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_levels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
rtl/rlss_pkg.sv
rtl/rlss_pixel_store.sv
rtl/rgb_led_strip_serializer.sv
verif/tb_top.sv
